// File: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Item kinds, result status codes and controller states.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] STATUS_LOADED = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_RAN    = 2'd2;
   localparam logic [1:0] STATUS_IDLE   = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_FINAL = 5'b10000
   } state_type;

endpackage

// File: rtl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table kept in a row of slot cells; each tick runs one unit of the most
// urgent ready task and reports preemption and completion.
//
//   channel  direction  accepted when
//   req_     in         req_tvalid && req_tready
//   rsp_     out        rsp_tvalid && rsp_tready
//
// A load item passes LOAD and FINAL; a tick item passes SCAN, while the
// candidate wave crosses the cell row one cell per cycle, then EXEC and FINAL.
// One item is in work at a time; the next is taken once the result is in
// the output register. Reset clears counts, time and the running task.
// A stalled result holds the block in its final state.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // task_id, arrival, burst, prio
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // now, running_id, preempted, displaced_id,
                                   // finished, finish_time, turnaround, waiting,
                                   // all_done, zero fill
   output logic [1:0]  rsp_tuser   // status
);

   localparam int CW = $clog2(MAX_TASKS+1);
   localparam int SW = $clog2(MAX_TASKS);

   state_type state_ff, state_in;

   logic [CW-1:0]        task_count_ff, done_count_ff, scan_cnt_ff;
   logic [TIME_BITS-1:0] tick_ff;
   logic [SW-1:0]        last_slot_ff;
   logic                 last_valid_ff;
   logic [7:0]           last_id_ff;

   logic [7:0]           id_ff, prio_ff;
   logic [TIME_BITS-1:0] arrival_ff;
   logic [15:0]          burst_ff;

   logic [1:0]           status_ff;
   logic [15:0]          now_ff;
   logic [7:0]           run_ff, disp_ff;
   logic                 pre_ff, fin_ff;
   logic [TIME_BITS-1:0] ftime_ff, tat_ff;
   logic [15:0]          rburst_ff;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [82:0]          rsp_data_ff;

   logic                 found    [MAX_TASKS+1];
   logic [SW-1:0]        slot     [MAX_TASKS+1];
   logic [7:0]           cprio    [MAX_TASKS+1];
   logic [TIME_BITS-1:0] carr     [MAX_TASKS+1];
   logic [15:0]          crem     [MAX_TASKS+1];
   logic [15:0]          cburst   [MAX_TASKS+1];
   logic [7:0]           cid      [MAX_TASKS+1];

   logic                 req_acc, load_ok, exec_ran, exec_fin, out_free;
   logic [TIME_BITS-1:0] fin_time, waiting;

   assign found[0]  = 1'b0;
   assign slot[0]   = '0;
   assign cprio[0]  = '0;
   assign carr[0]   = '0;
   assign crem[0]   = '0;
   assign cburst[0] = '0;
   assign cid[0]    = '0;

   assign load_ok  = (state_ff == ST_LOAD) && (task_count_ff != CW'(MAX_TASKS));
   assign exec_ran = (state_ff == ST_EXEC) && found[MAX_TASKS];
   assign exec_fin = exec_ran && (crem[MAX_TASKS] == 16'd1);

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      pps_cell #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS), .INDEX(i)) u_cell (
         .clock        (clock),
         .wr_en        (load_ok && (task_count_ff == CW'(i))),
         .wr_id        (id_ff),
         .wr_arrival   (arrival_ff),
         .wr_burst     (burst_ff),
         .wr_prio      (prio_ff),
         .dec_en       (exec_ran && (slot[MAX_TASKS] == SW'(i))),
         .task_count   (task_count_ff),
         .tick_now     (tick_ff),
         .in_found     (found[i]),
         .in_slot      (slot[i]),
         .in_prio      (cprio[i]),
         .in_arrival   (carr[i]),
         .in_remaining (crem[i]),
         .in_burst     (cburst[i]),
         .in_id        (cid[i]),
         .out_found    (found[i+1]),
         .out_slot     (slot[i+1]),
         .out_prio     (cprio[i+1]),
         .out_arrival  (carr[i+1]),
         .out_remaining(crem[i+1]),
         .out_burst    (cburst[i+1]),
         .out_id       (cid[i+1])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin_time   = tick_ff + TIME_BITS'(1);
   assign waiting    = TIME_BITS'(33'(tat_ff) - 33'(rburst_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc) state_in = (req_tuser == OP_TICK) ? ST_SCAN : ST_LOAD;
         ST_LOAD:  state_in = ST_FINAL;
         ST_SCAN:  if (scan_cnt_ff == CW'(MAX_TASKS - 1)) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_FINAL;
         ST_FINAL: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= '0;
         done_count_ff <= '0;
         scan_cnt_ff   <= '0;
         tick_ff       <= '0;
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) scan_cnt_ff <= '0;
         else if (state_ff == ST_SCAN) scan_cnt_ff <= scan_cnt_ff + CW'(1);
         if (load_ok) begin
            task_count_ff <= task_count_ff + CW'(1);
            if (burst_ff == 16'd0) done_count_ff <= done_count_ff + CW'(1);
         end
         if (state_ff == ST_EXEC) begin
            tick_ff <= fin_time;
            if (exec_ran) begin
               last_slot_ff  <= slot[MAX_TASKS];
               last_valid_ff <= !exec_fin;
            end
            if (exec_fin) done_count_ff <= done_count_ff + CW'(1);
         end
         if (state_ff == ST_FINAL && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         id_ff      <= req_tdata[7:0];
         arrival_ff <= TIME_BITS'(req_tdata[23:8]);
         burst_ff   <= req_tdata[39:24];
         prio_ff    <= req_tdata[47:40];
         now_ff     <= 16'(tick_ff);
      end
      if (state_ff == ST_LOAD) begin
         status_ff <= load_ok ? STATUS_LOADED : STATUS_FULL;
         run_ff    <= '0;
         pre_ff    <= 1'b0;
         disp_ff   <= '0;
         fin_ff    <= 1'b0;
         ftime_ff  <= '0;
         tat_ff    <= '0;
         rburst_ff <= '0;
      end
      if (state_ff == ST_EXEC) begin
         status_ff <= exec_ran ? STATUS_RAN : STATUS_IDLE;
         run_ff    <= exec_ran ? cid[MAX_TASKS] : 8'd0;
         pre_ff    <= exec_ran && last_valid_ff && (last_slot_ff != slot[MAX_TASKS]);
         disp_ff   <= (exec_ran && last_valid_ff && (last_slot_ff != slot[MAX_TASKS]))
                      ? last_id_ff : 8'd0;
         fin_ff    <= exec_fin;
         ftime_ff  <= exec_fin ? fin_time : '0;
         tat_ff    <= exec_fin ? (fin_time - carr[MAX_TASKS]) : '0;
         rburst_ff <= exec_fin ? cburst[MAX_TASKS] : 16'd0;
         if (exec_ran) last_id_ff <= cid[MAX_TASKS];
      end
      if (state_ff == ST_FINAL && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {done_count_ff == task_count_ff, 16'(waiting), 16'(tat_ff),
                           16'(ftime_ff), fin_ff, disp_ff, pre_ff, run_ff, now_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("item accepted while busy");

   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (done_count_ff <= task_count_ff) && (task_count_ff <= CW'(MAX_TASKS)))
      else $error("task counts out of range");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_IDLE)) |-> (rsp_tdata[33:16] == 18'd0))
      else $error("idle result carries task fields");

endmodule

// File: rtl/pps_cell.sv
// ----------------------------------------------------------------------------
// Scheduler slot cell
// Holds one task slot and passes the best ready candidate seen so far to the
// next cell every cycle.
// ----------------------------------------------------------------------------
module pps_cell import pps_pkg::*; #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 16,
   parameter int INDEX     = 0
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [7:0]                           wr_id,
   input  logic [TIME_BITS-1:0]                 wr_arrival,
   input  logic [15:0]                          wr_burst,
   input  logic [7:0]                           wr_prio,
   input  logic                                 dec_en,
   input  logic [$clog2(MAX_TASKS+1)-1:0]       task_count,
   input  logic [TIME_BITS-1:0]                 tick_now,
   input  logic                                 in_found,
   input  logic [$clog2(MAX_TASKS)-1:0]         in_slot,
   input  logic [7:0]                           in_prio,
   input  logic [TIME_BITS-1:0]                 in_arrival,
   input  logic [15:0]                          in_remaining,
   input  logic [15:0]                          in_burst,
   input  logic [7:0]                           in_id,
   output logic                                 out_found,
   output logic [$clog2(MAX_TASKS)-1:0]         out_slot,
   output logic [7:0]                           out_prio,
   output logic [TIME_BITS-1:0]                 out_arrival,
   output logic [15:0]                          out_remaining,
   output logic [15:0]                          out_burst,
   output logic [7:0]                           out_id
);

   localparam int CW = $clog2(MAX_TASKS+1);
   localparam int SW = $clog2(MAX_TASKS);

   logic [7:0]           id_ff;
   logic [TIME_BITS-1:0] arrival_ff;
   logic [15:0]          burst_ff;
   logic [7:0]           prio_ff;
   logic [15:0]          remaining_ff;

   logic                 found_ff;
   logic [SW-1:0]        slot_ff;
   logic [7:0]           cprio_ff;
   logic [TIME_BITS-1:0] carrival_ff;
   logic [15:0]          cremaining_ff;
   logic [15:0]          cburst_ff;
   logic [7:0]           cid_ff;

   logic eligible;
   logic take;

   assign eligible = (CW'(INDEX) < task_count) && (arrival_ff <= tick_now)
                     && (remaining_ff != 16'd0);
   assign take = eligible && (!in_found || (prio_ff < in_prio)
                 || ((prio_ff == in_prio) && (arrival_ff < in_arrival)));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_ff        <= wr_id;
         arrival_ff   <= wr_arrival;
         burst_ff     <= wr_burst;
         prio_ff      <= wr_prio;
         remaining_ff <= wr_burst;
      end else if (dec_en) begin
         remaining_ff <= remaining_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         found_ff      <= 1'b1;
         slot_ff       <= SW'(INDEX);
         cprio_ff      <= prio_ff;
         carrival_ff   <= arrival_ff;
         cremaining_ff <= remaining_ff;
         cburst_ff     <= burst_ff;
         cid_ff        <= id_ff;
      end else begin
         found_ff      <= in_found;
         slot_ff       <= in_slot;
         cprio_ff      <= in_prio;
         carrival_ff   <= in_arrival;
         cremaining_ff <= in_remaining;
         cburst_ff     <= in_burst;
         cid_ff        <= in_id;
      end
   end

   assign out_found     = found_ff;
   assign out_slot      = slot_ff;
   assign out_prio      = cprio_ff;
   assign out_arrival   = carrival_ff;
   assign out_remaining = cremaining_ff;
   assign out_burst     = cburst_ff;
   assign out_id        = cid_ff;

endmodule

// File: sim/tb_preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load and tick items with random gaps and receiver stalls, predicts
// every result from a local model of the task table and compares each field.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler import pps_pkg::*;;

   localparam int NUM_SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] now;
      logic [7:0]  running_id;
      logic        preempted;
      logic [7:0]  displaced_id;
      logic        finished;
      logic [15:0] finish_time;
      logic [15:0] turnaround;
      logic [15:0] waiting;
      logic        all_done;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   logic [7:0]  tbl_id [NUM_SLOTS];
   logic [15:0] tbl_arrival [NUM_SLOTS];
   logic [15:0] tbl_burst [NUM_SLOTS];
   logic [7:0]  tbl_prio [NUM_SLOTS];
   logic [15:0] tbl_left [NUM_SLOTS];
   int          tbl_count;
   int          done_tasks;
   logic [15:0] sched_now;
   int          prev_slot;
   logic        prev_valid;

   sched_result_type expected_results[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  hold_off = 0;
   bit  stall_mode = 1'b0;

   always #5 clock = ~clock;

   preemptive_priority_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   function automatic int random_gap();
      if ($urandom_range(0, 9) < 4) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 4);
   endfunction

   function automatic sched_result_type schedule_item(logic op, logic [7:0] id,
         logic [15:0] arr, logic [15:0] burst, logic [7:0] prio);
      sched_result_type r;
      int best;
      r = '0;
      r.now = sched_now;
      if (op == OP_LOAD) begin
         if (tbl_count >= NUM_SLOTS) begin
            r.status = STATUS_FULL;
         end else begin
            tbl_id[tbl_count] = id;
            tbl_arrival[tbl_count] = arr;
            tbl_burst[tbl_count] = burst;
            tbl_prio[tbl_count] = prio;
            tbl_left[tbl_count] = burst;
            if (burst == 0) done_tasks++;
            tbl_count++;
            r.status = STATUS_LOADED;
         end
      end else begin
         best = -1;
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_arrival[i] <= sched_now && tbl_left[i] != 0) begin
               if (best < 0 || tbl_prio[i] < tbl_prio[best] ||
                   (tbl_prio[i] == tbl_prio[best] && tbl_arrival[i] < tbl_arrival[best]))
                  best = i;
            end
         end
         if (best < 0) begin
            r.status = STATUS_IDLE;
         end else begin
            r.status = STATUS_RAN;
            r.running_id = tbl_id[best];
            if (prev_valid && prev_slot != best) begin
               r.preempted = 1'b1;
               r.displaced_id = tbl_id[prev_slot];
            end
            tbl_left[best] = tbl_left[best] - 16'd1;
            prev_slot = best;
            prev_valid = 1'b1;
            if (tbl_left[best] == 0) begin
               r.finished = 1'b1;
               r.finish_time = sched_now + 16'd1;
               r.turnaround = r.finish_time - tbl_arrival[best];
               r.waiting = r.turnaround - tbl_burst[best];
               done_tasks++;
               prev_valid = 1'b0;
            end
         end
         sched_now = sched_now + 16'd1;
      end
      r.all_done = (done_tasks == tbl_count);
      return r;
   endfunction

   task automatic send_item(logic op, logic [7:0] id, logic [15:0] arr,
         logic [15:0] burst, logic [7:0] prio);
      int gap;
      gap = stall_mode ? 0 : random_gap();
      repeat (gap + 1) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {prio, burst, arr, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(schedule_item(op, id, arr, burst, prio));
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic load_task(logic [7:0] id, logic [15:0] arr, logic [15:0] burst,
         logic [7:0] prio);
      send_item(OP_LOAD, id, arr, burst, prio);
   endtask

   task automatic tick_item();
      send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (NUM_SLOTS + 8) @(negedge clock);
   endtask

   // Time keeps running across the whole run; reset happens once only.
   task automatic test_directed();
      tick_item();
      load_task(8'hFF, 16'd0, 16'd0, 8'd0);
      load_task(8'h00, sched_now, 16'd3, 8'd200);
      load_task(8'hA5, sched_now + 16'd2, 16'd2, 8'd5);
      load_task(8'h5A, sched_now, 16'd1, 8'd200);
      repeat (8) tick_item();
      load_task(8'h11, 16'hFFFF, 16'hFFFF, 8'hFF);
      load_task(8'h22, sched_now, 16'd2, 8'd9);
      load_task(8'h33, sched_now, 16'd2, 8'd9);
      repeat (5) tick_item();
      wait_drained();
   endtask

   task automatic test_fill_table();
      while (tbl_count < NUM_SLOTS)
         load_task(8'($urandom), 16'(sched_now + $urandom_range(0, 3)),
                   16'($urandom_range(1, 3)), 8'($urandom_range(0, 3)));
      load_task(8'h77, 16'd0, 16'd1, 8'd0);
      load_task(8'h88, 16'd5, 16'd2, 8'd1);
      repeat (40) tick_item();
      wait_drained();
   endtask

   task automatic test_random();
      int n;
      n = 0;
      while (n < 1280) begin
         if (tbl_count < NUM_SLOTS && $urandom_range(0, 3) == 0)
            load_task(8'($urandom), 16'(sched_now + $urandom_range(0, 6) -
                      ($urandom_range(0, 9) == 0 ? 16'd3 : 16'd0)),
                      $urandom_range(0, 9) == 0 ? 16'(0) : 16'($urandom_range(1, 6)),
                      $urandom_range(0, 15) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)));
         else if ($urandom_range(0, 49) == 0)
            load_task(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
         else
            tick_item();
         n++;
      end
      wait_drained();
   endtask

   task automatic test_back_pressure();
      stall_mode = 1'b1;
      hold_off = 300;
      repeat (30) tick_item();
      stall_mode = 1'b0;
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7);
      end
   end

   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[23:16], rsp_tdata[24],
                rsp_tdata[32:25], rsp_tdata[33], rsp_tdata[49:34], rsp_tdata[65:50],
                rsp_tdata[81:66], rsp_tdata[82]};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          expected_results.size() == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_preemptive_priority_scheduler NOT OK");
         $finish;
      end
   end

   initial begin
      tbl_count = 0;
      done_tasks = 0;
      sched_now = '0;
      prev_slot = 0;
      prev_valid = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_back_pressure();
      test_fill_table();
      test_random();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_preemptive_priority_scheduler OK");
      else
         $display("tb_preemptive_priority_scheduler NOT OK");
      $finish;
   end

endmodule
